FILE: src/mrp_pkg.sv
`default_nettype none
package mrp_pkg;

  // witness lfsr feedback taps
  localparam logic [31:0] LfsrTaps = 32'h80200003;
  localparam int unsigned MaxRounds = 64;
  localparam int unsigned RoundsW = 7;

  // configuration register indexes
  localparam logic RegRounds = 1'b0;
  localparam logic RegSeed = 1'b1;

  // one step of the galois lfsr
  function automatic logic [31:0] lfsr_step(input logic [31:0] v);
    logic [31:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LfsrTaps;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: src/miller_rabin_primality.sv
// Miller-Rabin primality tester. One candidate is taken at a time; ready is low while
// a test runs and while a finished result still waits to be taken, so the next candidate
// is accepted only after the previous result has left. Trivial candidates (n<=1, even,
// 2, 3) pass through the check and done states only. Odd n>=5 runs one shared modular
// unit: each modular product is a 32x32 multiply, then a restoring bit-serial
// reduction of the 64-bit product, one bit per cycle, then a step to take the
// remainder, plus a sequencer step per exponent bit or squaring. A w mod (n-4)
// reduction per round runs through the same unit. Composites usually stop in the
// first round.
`default_nettype none
module miller_rabin_primality #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] candidate_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             likely_prime_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned W = NUM_WIDTH;
  // wide enough for a full product and for the 32-bit witness word
  localparam int unsigned PW = (2 * W < 32) ? 32 : 2 * W;
  localparam int unsigned CW = $clog2(PW + 1);
  localparam int unsigned RW = $clog2(W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SPLIT, S_WIT, S_POW, S_SQ, S_MUL, S_RED, S_DONE
  } state_e;

  // what to do with the result of the modular unit
  typedef enum logic [2:0] {
    K_WIT, K_ACC, K_BASE, K_SQ
  } kind_e;

  state_e        state_q;
  kind_e         kind_q;
  logic [6:0]    rounds_q;
  logic [31:0]   lfsr_q;
  logic [W-1:0]  n_q, d_q, e_q;
  logic [RW-1:0] r_q, j_q;
  logic [6:0]    k_q;
  logic [W-1:0]  acc_q, base_q;
  logic [W-1:0]  ma_q, mb_q, mod_q;
  logic [PW-1:0] prod_q;
  logic [W:0]    rem_q;
  logic [CW-1:0] cnt_q;
  logic          res_q, ovalid_q;

  logic [W-1:0]  n_in;
  logic [W:0]    rem_sh;
  logic [6:0]    k_lim;
  logic [W-1:0]  nm1;

  assign n_in = candidate_i[W-1:0];
  assign nm1 = n_q - W'(1);
  assign rem_sh = {rem_q[W-1:0], prod_q[PW-1]};
  assign k_lim = (rounds_q == 7'd0) ? 7'd1 :
                 (rounds_q > 7'(mrp_pkg::MaxRounds)) ? 7'(mrp_pkg::MaxRounds) : rounds_q;

  assign in_ready_o = (state_q == S_IDLE) && !ovalid_q;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign likely_prime_o = res_q;

  // sequencer, lfsr and shared modular unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= K_WIT;
      rounds_q <= 7'd5;
      lfsr_q   <= 32'd1;
      ovalid_q <= 1'b0;
      res_q    <= 1'b0;
      n_q      <= '0;
      d_q      <= '0;
      e_q      <= '0;
      r_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      acc_q    <= '0;
      base_q   <= '0;
      ma_q     <= '0;
      mb_q     <= '0;
      mod_q    <= '0;
      prod_q   <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
    end else begin
      if (ovalid_q && out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            if (cfg_index_i == mrp_pkg::RegRounds) begin
              rounds_q <= cfg_data_i[6:0];
            end else begin
              lfsr_q <= cfg_data_i;
            end
          end
          if (in_valid_i && in_ready_o) begin
            n_q <= n_in;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (n_q <= W'(1) || (!n_q[0] && n_q != W'(2))) begin
            res_q <= 1'b0;
            state_q <= S_DONE;
          end else if (n_q == W'(2) || n_q == W'(3)) begin
            res_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            d_q <= nm1;
            r_q <= '0;
            k_q <= '0;
            state_q <= S_SPLIT;
          end
        end
        // strip trailing zeros of n-1
        S_SPLIT: begin
          if (!d_q[0]) begin
            d_q <= d_q >> 1;
            r_q <= r_q + RW'(1);
          end else begin
            lfsr_q <= mrp_pkg::lfsr_step(lfsr_q);
            // reduce witness word modulo n-4 (mult by one)
            prod_q <= PW'(mrp_pkg::lfsr_step(lfsr_q));
            mod_q <= n_q - W'(4);
            kind_q <= K_WIT;
            rem_q <= '0;
            cnt_q <= CW'(PW);
            state_q <= S_RED;
          end
        end
        // one step of square-and-multiply
        S_POW: begin
          if (e_q == '0) begin
            if (acc_q == W'(1) || acc_q == nm1) begin
              state_q <= S_WIT;
            end else begin
              j_q <= RW'(1);
              state_q <= S_SQ;
            end
          end else if (e_q[0]) begin
            ma_q <= acc_q; mb_q <= base_q; kind_q <= K_ACC; state_q <= S_MUL;
          end else begin
            ma_q <= base_q; mb_q <= base_q; kind_q <= K_BASE; state_q <= S_MUL;
          end
        end
        // repeated squaring
        S_SQ: begin
          if (j_q >= r_q) begin
            res_q <= 1'b0;
            state_q <= S_DONE;
          end else begin
            ma_q <= acc_q; mb_q <= acc_q; kind_q <= K_SQ; state_q <= S_MUL;
          end
        end
        S_WIT: begin
          if (k_q + 7'd1 >= k_lim) begin
            res_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            k_q <= k_q + 7'd1;
            lfsr_q <= mrp_pkg::lfsr_step(lfsr_q);
            prod_q <= PW'(mrp_pkg::lfsr_step(lfsr_q));
            mod_q <= n_q - W'(4);
            kind_q <= K_WIT;
            rem_q <= '0;
            cnt_q <= CW'(PW);
            state_q <= S_RED;
          end
        end
        S_MUL: begin
          prod_q <= PW'(ma_q) * PW'(mb_q);
          mod_q <= n_q;
          rem_q <= '0;
          cnt_q <= CW'(PW);
          state_q <= S_RED;
        end
        // restoring reduction, one product bit a cycle
        S_RED: begin
          if (cnt_q != '0) begin
            prod_q <= prod_q << 1;
            cnt_q <= cnt_q - CW'(1);
            rem_q <= (rem_sh >= {1'b0, mod_q}) ? rem_sh - {1'b0, mod_q} : rem_sh;
          end else begin
            unique case (kind_q)
              K_WIT: begin
                base_q <= rem_q[W-1:0] + W'(2);
                acc_q <= W'(1);
                e_q <= d_q;
                state_q <= S_POW;
              end
              K_ACC: begin
                acc_q <= rem_q[W-1:0];
                ma_q <= base_q; mb_q <= base_q; kind_q <= K_BASE;
                state_q <= S_MUL;
              end
              K_BASE: begin
                base_q <= rem_q[W-1:0];
                e_q <= e_q >> 1;
                state_q <= S_POW;
              end
              default: begin
                acc_q <= rem_q[W-1:0];
                j_q <= j_q + RW'(1);
                if (rem_q[W-1:0] == nm1) begin
                  state_q <= S_WIT;
                end else begin
                  state_q <= S_SQ;
                end
              end
            endcase
          end
        end
        S_DONE: begin
          ovalid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  a_red_lt_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RED) |-> (rem_q < {1'b0, mod_q}))
    else $error("remainder out of range");
  a_busy_no_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("ready while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> out_valid_o)
    else $error("result lost");

endmodule
`default_nettype wire

FILE: test/mrp_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module mrp_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [31:0] candidate_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic        likely_prime_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output int               pending_o,
  output int               errors_o
);

  logic [mrp_pkg::RoundsW-1:0] rounds_q;
  logic [31:0]                 witness_q;
  bit                          verdict_q[$];

  // (x * y) mod m, exact since both operands stay below 2^32
  function automatic longint unsigned mulmod(longint unsigned x, longint unsigned y,
                                             longint unsigned m);
    return (x * y) % m;
  endfunction

  function automatic longint unsigned powmod(longint unsigned b, longint unsigned e,
                                             longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    b = b % m;
    while (e > 0) begin
      if (e[0]) acc = mulmod(acc, b, m);
      e = e >> 1;
      b = mulmod(b, b, m);
    end
    return acc;
  endfunction

  // predicts one verdict, advancing the witness lfsr once per round run
  function automatic bit primality_verdict(logic [31:0] cand);
    longint unsigned n, d, a, x;
    int r, k;
    logic [31:0] w;
    bit composite;
    n = cand;
    if (n <= 1) return 1'b0;
    if (n == 2 || n == 3) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    d = n - 1;
    r = 0;
    while (d[0] == 1'b0) begin
      d = d >> 1;
      r++;
    end
    k = rounds_q;
    if (k == 0) k = 1;
    if (k > mrp_pkg::MaxRounds) k = mrp_pkg::MaxRounds;
    for (int i = 0; i < k; i++) begin
      w = witness_q >> 1;
      if (witness_q[0]) w = w ^ 32'h80200003;
      witness_q = w;
      a = 2 + (longint'(w) % (n - 4));
      x = powmod(a, d, n);
      if (x == 1 || x == n - 1) continue;
      composite = 1'b1;
      for (int j = 0; j + 1 < r; j++) begin
        x = mulmod(x, x, n);
        if (x == n - 1) begin
          composite = 1'b0;
          break;
        end
      end
      if (composite) return 1'b0;
    end
    return 1'b1;
  endfunction

  assign pending_o = verdict_q.size();

  // track config, predict on accepted items, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    bit exp_v;
    if (!rst_ni) begin
      rounds_q  = 5;
      witness_q = 32'd1;
      verdict_q.delete();
      errors_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result %0b", likely_prime_i);
        end else begin
          exp_v = verdict_q.pop_front();
          if (likely_prime_i !== exp_v) begin
            errors_o++;
            if (errors_o <= 10)
              $display("likely_prime mismatch: expected %0b actual %0b", exp_v, likely_prime_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == mrp_pkg::RegRounds) begin
          rounds_q = cfg_data_i[mrp_pkg::RoundsW-1:0];
        end else if (cfg_index_i == mrp_pkg::RegSeed) begin
          witness_q = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_i) verdict_q.push_back(primality_verdict(candidate_i));
    end
  end
endmodule
`default_nettype wire

FILE: test/tb_miller_rabin_primality.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_miller_rabin_primality;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] candidate_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        likely_prime_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          pending;
  int          errors;
  int          burst_left = 0;

  always #2 clk_i = ~clk_i;

  miller_rabin_primality u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .candidate_i, .out_valid_o,
    .out_ready_i, .likely_prime_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  mrp_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .candidate_i,
    .out_valid_i(out_valid_o), .out_ready_i, .likely_prime_i(likely_prime_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  // offer one item, in bursts with random gaps
  task automatic send_candidate(logic [31:0] cand);
    in_valid_i  <= 1'b1;
    candidate_i <= cand;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  endtask

  // hold input until every expected result has come
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_candidate();
    logic [31:0] primes[8] = '{32'd65521, 32'd2147483647, 32'd4294967291, 32'd1000003,
                               32'd104729, 32'd7919, 32'd3, 32'd2};
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom() | 32'd1;
    if (sel < 8) return $urandom_range(0, 1000);
    if (sel < 9) return $urandom() & ~32'd1;
    return primes[$urandom_range(0, 7)];
  endfunction

  // receiver: long hold-off first so the block backs up, then random stalls
  initial begin
    @(posedge rst_ni);
    repeat (400) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 1) == 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(10, 60)) begin
          out_ready_i <= ($urandom_range(0, 9) < 6);
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    logic [31:0] directed_a[15] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'hFFFFFFFE,
                                    32'hFFFFFFFF, 32'd5, 32'd7, 32'd9, 32'd561,
                                    32'd4294967291, 32'h80000000, 32'd25, 32'd97};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    burst_left = 8;

    // reset configuration: bounds, trivial and odd candidates
    foreach (directed_a[i]) send_candidate(directed_a[i]);
    drain_results();

    // zero rounds acts as one; zero seed pins the witness to 2
    write_reg(mrp_pkg::RegRounds, 32'd0);
    write_reg(mrp_pkg::RegSeed, 32'd0);
    send_candidate(32'd4294967291);
    send_candidate(32'd341);
    send_candidate(32'd2047);
    send_candidate(32'd3215031751);
    drain_results();

    // rounds above range saturate; prime runs all rounds
    write_reg(mrp_pkg::RegRounds, 32'd127);
    write_reg(mrp_pkg::RegSeed, 32'hFFFFFFFF);
    send_candidate(32'd5);
    send_candidate(32'd1000001);
    send_candidate(32'd561);
    drain_results();

    // random candidates over two settings
    write_reg(mrp_pkg::RegRounds, 32'd1);
    write_reg(mrp_pkg::RegSeed, $urandom() | 32'd1);
    repeat (70) send_candidate(random_candidate());
    drain_results();
    write_reg(mrp_pkg::RegRounds, 32'd2);
    write_reg(mrp_pkg::RegSeed, $urandom());
    repeat (70) send_candidate(random_candidate());
    drain_results();

    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #80000000;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
